@@ rtl/pchc_pkg.sv @@
// pchc_pkg: shared types and constants for the PAN channel hop classifier.
// Used by pchc_table, pchc_score and pan_channel_hop_classifier. No dependencies.
`default_nettype none

package pchc_pkg;

  localparam int DEF_TABLE_SLOTS = 16;

  localparam logic       CMD_RECORD   = 1'b0;
  localparam logic       CMD_SCORE    = 1'b1;

  localparam logic [15:0] BROADCAST_ID = 16'hFFFF;
  localparam logic [7:0]  CHAN_FIRST   = 8'd11;
  localparam logic [7:0]  CHAN_LAST    = 8'd26;
  localparam logic [2:0]  FRAME_BEACON = 3'd0;
  localparam logic [1:0]  VERSION_ZERO = 2'd0;
  localparam logic [1:0]  ADDR_SHORT   = 2'd2;
  localparam logic [15:0] FRAMES_MAX   = 16'hFFFF;

  localparam logic [6:0] PTS_SECURED = 7'd20;
  localparam logic [6:0] PTS_VERSION = 7'd5;
  localparam logic [6:0] PTS_SHORT   = 7'd5;
  localparam logic [6:0] PTS_CH4     = 7'd70;
  localparam logic [6:0] PTS_CH3     = 7'd50;
  localparam logic [6:0] PTS_CH2     = 7'd30;
  localparam logic [6:0] PTS_BEACON  = 7'd5;
  localparam logic [6:0] SCORE_MAX   = 7'd100;

  typedef struct packed {
    logic [15:0] network;
    logic [15:0] channels;
    logic [15:0] frames;
    logic        secure_seen;
    logic        beacon_seen;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/pchc_table.sv @@
// pchc_table: slot memory with one write port and one registered read port,
// plus per-slot valid flops cleared by reset. Depends on pchc_pkg.
`default_nettype none

module pchc_table
  import pchc_pkg::*;
#(
  parameter int SLOTS = DEF_TABLE_SLOTS,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [IDX_W-1:0] rd_addr,
  output entry_t                rd_data,
  output logic                  rd_valid,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire entry_t           wr_data
);

  entry_t mem [SLOTS];
  logic [SLOTS-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/pchc_score.sv @@
// pchc_score: builds the 0..100 likelihood from query fields and the hit entry.
// Depends on pchc_pkg.
`default_nettype none

module pchc_score
  import pchc_pkg::*;
(
  input  wire logic        broadcast,
  input  wire logic        secured,
  input  wire logic [1:0]  version_field,
  input  wire logic [1:0]  address_mode,
  input  wire logic        hit,
  input  wire logic [15:0] channels,
  input  wire logic        beacon_seen,
  output logic [6:0]       likelihood
);

  logic [4:0] n_chan;
  logic [6:0] sum;

  always_comb begin
    n_chan = 5'($countones(channels));
    sum    = '0;
    if (secured)                     sum = sum + PTS_SECURED;
    if (version_field == VERSION_ZERO) sum = sum + PTS_VERSION;
    if (address_mode == ADDR_SHORT)    sum = sum + PTS_SHORT;
    if (hit) begin
      if (n_chan >= 5'd4)      sum = sum + PTS_CH4;
      else if (n_chan == 5'd3) sum = sum + PTS_CH3;
      else if (n_chan == 5'd2) sum = sum + PTS_CH2;
      if (beacon_seen)         sum = sum + PTS_BEACON;
    end
    if (broadcast)             likelihood = '0;
    else if (sum > SCORE_MAX)  likelihood = SCORE_MAX;
    else                       likelihood = sum;
  end

endmodule

`default_nettype wire

@@ rtl/pan_channel_hop_classifier.sv @@
// pan_channel_hop_classifier: top level, scan sequencer over the slot table.
// Depends on pchc_pkg, pchc_table, pchc_score.
//
//   channel  direction  signals
//   in       sink       in_valid, in_ready, cmd, network_id, kind_of_frame,
//                       secured, radio_channel, version_field, address_mode
//   out      source     out_valid, out_ready, likelihood
//
// Items are taken one at a time. The table is scanned slot by slot through its
// single registered read port, each slot passing through S_READ then S_CHECK,
// stopping at a match or at the last slot. A record that is filtered out is
// dropped in S_IDLE. Reset clears valid flops and the fill count. A result waits
// in the output register; the next item is taken meanwhile, and only a new result
// stalls until the previous one is transferred.
`default_nettype none

module pan_channel_hop_classifier
  import pchc_pkg::*;
#(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd,
  input  wire logic [15:0] network_id,
  input  wire logic [2:0]  kind_of_frame,
  input  wire logic        secured,
  input  wire logic [7:0]  radio_channel,
  input  wire logic [1:0]  version_field,
  input  wire logic [1:0]  address_mode,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       likelihood
);

  localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_CHECK = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;

  // latched item
  logic        cmd_q;
  logic [15:0] id_q;
  logic [2:0]  kind_q;
  logic        sec_q;
  logic [7:0]  chan_q;
  logic [1:0]  ver_q;
  logic [1:0]  amode_q;

  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] victim;
  logic [15:0]      min_frames;
  logic             min_set;
  logic             hit;
  entry_t           hit_entry;
  logic [CNT_W-1:0] slots_used;

  entry_t           rd_data;
  logic             rd_valid;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  entry_t           base;
  logic [6:0]       score;

  logic accept, drop, id_bcast, chan_ok, match, last, full, load_out;
  logic [3:0] chan_bit;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign id_bcast = (network_id == BROADCAST_ID);
  assign chan_ok  = (radio_channel >= CHAN_FIRST) && (radio_channel <= CHAN_LAST);
  assign drop     = (cmd == CMD_RECORD) && (id_bcast || !chan_ok);
  assign match    = rd_valid && (rd_data.network == id_q);
  assign last     = (scan_idx == IDX_W'(TABLE_SLOTS - 1));
  assign full     = (slots_used == CNT_W'(TABLE_SLOTS));
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);
  assign chan_bit = 4'(chan_q - CHAN_FIRST);

  pchc_table #(.SLOTS(TABLE_SLOTS)) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (scan_idx),
    .rd_data  (rd_data),
    .rd_valid (rd_valid),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  pchc_score u_score (
    .broadcast     (id_q == BROADCAST_ID),
    .secured       (sec_q),
    .version_field (ver_q),
    .address_mode  (amode_q),
    .hit           (hit),
    .channels      (hit_entry.channels),
    .beacon_seen   (hit_entry.beacon_seen),
    .likelihood    (score)
  );

  // record update: hit entry, fresh slot, or evicted lowest-count slot
  always_comb begin
    base = '0;
    if (hit) begin
      wr_addr = hit_idx;
      base    = hit_entry;
    end else if (!full) begin
      wr_addr = slots_used[IDX_W-1:0];
    end else begin
      wr_addr = victim;
    end
    base.network = id_q;
    wr_data = base;
    wr_data.channels    = base.channels | (16'd1 << chan_bit);
    wr_data.frames      = (base.frames != FRAMES_MAX) ? base.frames + 16'd1 : base.frames;
    wr_data.secure_seen = base.secure_seen | sec_q;
    wr_data.beacon_seen = base.beacon_seen | (kind_q == FRAME_BEACON);
    wr_en = (state == S_WRITE);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && !drop) begin
          if (cmd == CMD_SCORE && id_bcast) state_next = S_DONE;
          else                              state_next = S_READ;
        end
      end
      S_READ:  state_next = S_CHECK;
      S_CHECK: begin
        if (match || last) begin
          state_next = (cmd_q == CMD_RECORD) ? S_WRITE : S_DONE;
        end else begin
          state_next = S_READ;
        end
      end
      S_WRITE: state_next = S_IDLE;
      S_DONE:  if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slots_used <= '0;
      out_valid  <= 1'b0;
      hit        <= 1'b0;
      min_set    <= 1'b0;
      scan_idx   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        hit      <= 1'b0;
        min_set  <= 1'b0;
        scan_idx <= '0;
      end
      if (state == S_CHECK) begin
        if (match) begin
          hit <= 1'b1;
        end else begin
          if (rd_valid && (!min_set || rd_data.frames < min_frames)) begin
            min_set <= 1'b1;
          end
          if (!last) scan_idx <= scan_idx + 1'b1;
        end
      end
      if (wr_en && !hit && !full) begin
        slots_used <= slots_used + 1'b1;
      end
      if (load_out)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= cmd;
      id_q    <= network_id;
      kind_q  <= kind_of_frame;
      sec_q   <= secured;
      chan_q  <= radio_channel;
      ver_q   <= version_field;
      amode_q <= address_mode;
    end
    if (state == S_CHECK) begin
      if (match) begin
        hit_idx   <= scan_idx;
        hit_entry <= rd_data;
      end else if (rd_valid && (!min_set || rd_data.frames < min_frames)) begin
        min_frames <= rd_data.frames;
        victim     <= scan_idx;
      end
    end
    if (load_out) likelihood <= score;
  end

`ifndef SYNTHESIS
  a_write_only_record: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (cmd_q == CMD_RECORD))
    else $error("table write during score query");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= CNT_W'(TABLE_SLOTS))
    else $error("fill count beyond table size");

  a_result_from_score: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (cmd_q == CMD_SCORE))
    else $error("result produced by a record item");

  a_score_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (likelihood <= SCORE_MAX))
    else $error("likelihood above clamp");

  a_evict_when_full: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !hit && full) |-> min_set)
    else $error("eviction without a victim");
`endif

endmodule

`default_nettype wire
